[hw/rtl/dma_pkg.sv]
// Shared types and constants of the dropout mask datapath.
`default_nettype none

package dma_pkg;

    // Logit table word: signed Q5.10.
    typedef logic signed [15:0] logit_t;

    // Sigmoid table word: 1 - sigmoid(x) as unsigned Q1.16, 0 to 65536.
    typedef logic [16:0] sig_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE            = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SCALE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOGIT_P         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_TEMPERATURE = 3'd4;

    // Mode codes.
    localparam logic MODE_MC       = 1'b0;
    localparam logic MODE_CONCRETE = 1'b1;

    // Fixed point constants used when the tables are built.
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

endpackage

`default_nettype wire

[hw/rtl/dma_tables.sv]
// Logit and sigmoid lookup tables, built at elaboration, with registered reads.
`default_nettype none

module dma_tables
    import dma_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [TABLE_BITS-1:0] logit_addr,
    input  wire logic [TABLE_BITS-1:0] sig_addr,
    output logit_t                     logit_data,
    output sig_t                       sig_data
);

    localparam int TSIZE = 1 << TABLE_BITS;

    typedef logit_t logit_tab_t [TSIZE];
    typedef sig_t   sig_tab_t [TSIZE];

    // Unsigned shift-subtract division, used only while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Base-two logarithm of a positive integer by repeated squaring, Q30.
    function automatic logic [63:0] int_log2_q30(input logic [63:0] x);
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] frac;
        k = '0;
        frac = '0;
        for (int s = 1; s <= 20; s++) begin
            if ((x >> s) != 64'd0) begin
                k = 64'(s);
            end
        end
        m = x << (64'd30 - k);
        for (int b = 29; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (Q30_ONE << 1)) begin
                m = m >> 1;
                frac = frac | (64'd1 << b);
            end
        end
        return (k << 30) | frac;
    endfunction

    // e to the power -y for y >= 0, Q30 in and out.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        n = udiv64(y, LN2_Q30);
        r = y - n * LN2_Q30;
        sum = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * r) >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (n >= 64'd63) ? 64'd0 : (sum >> n);
    endfunction

    // Logit table: entry i holds ln(a / (N - a)), a = 2i + 1, N = 2 * TSIZE.
    function automatic logit_tab_t build_logit();
        logit_tab_t  tab;
        logic [63:0] full;
        logic [63:0] a;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] d;
        logic [63:0] mag;
        logic        neg;
        full = 64'd1 << (TABLE_BITS + 1);
        for (int i = 0; i < TSIZE; i++) begin
            a   = 64'(2 * i + 1);
            la  = int_log2_q30(a);
            lb  = int_log2_q30(full - a);
            neg = la < lb;
            d   = neg ? lb - la : la - lb;
            mag = (((d >> 8) * LN2_Q30) + (64'd1 << 41)) >> 42;
            tab[i] = neg ? -logit_t'(mag[15:0]) : logit_t'(mag[15:0]);
        end
        return tab;
    endfunction

    // Sigmoid table: entry j holds 1 - sigmoid(x) at the center of its bin.
    function automatic sig_tab_t build_sig();
        sig_tab_t    tab;
        logic [63:0] a;
        logic [63:0] half;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] val;
        half = 64'd1 << 34;
        for (int i = 0; i < TSIZE; i++) begin
            a = 64'(2 * i + 1) << (34 - TABLE_BITS);
            if (a >= half) begin
                e   = exp_neg_q30(a - half);
                den = Q30_ONE + e;
                val = udiv64((e << 16) + (den >> 1), den);
            end else begin
                e   = exp_neg_q30(half - a);
                den = Q30_ONE + e;
                val = udiv64((64'd1 << 46) + (den >> 1), den);
            end
            tab[i] = val[16:0];
        end
        return tab;
    endfunction

    localparam logit_tab_t LOGIT_ROM = build_logit();
    localparam sig_tab_t   SIG_ROM   = build_sig();

    // Both tables are read together while the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logit_data <= LOGIT_ROM[logit_addr];
            sig_data   <= SIG_ROM[sig_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dropout_mask_apply.sv]
// Dropout mask datapath: Monte Carlo and concrete dropout on a Q8.8 stream.
//
//   channel   direction  handshake             word
//   in        sink       in_valid / in_stall   activation, random_word, last_in
//   out       source     out_valid / out_stall scaled_value, saturated, last_out
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word enters per cycle unless the output stalls; the depth is set by
// the two registered table reads and the three multipliers.
// Reset clears the valid bits and loads the register defaults; the tables are
// constant, so no clearing pass is needed.
// A stall at the output holds every stage at once; in_stall rises only while
// the output register is full and stalled.
`default_nettype none

module dropout_mask_apply
    import dma_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input channel.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [15:0]            activation,
    input  wire logic        [15:0]            random_word,
    input  wire logic                          last_in,
    // Output channel.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed      [15:0]            scaled_value,
    output logic                               saturated,
    output logic                               last_out,
    // Configuration channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [15:0]            cfg_data
);

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int SHW   = 11 + TABLE_BITS;

    // Configuration registers.
    logic        mode_reg;
    logic [15:0] drop_threshold_reg;
    logic [15:0] keep_scale_reg;
    logic signed [15:0] logit_p_reg;
    logic [15:0] inv_temperature_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_MC;
            drop_threshold_reg  <= 16'd32768;
            keep_scale_reg      <= 16'd8192;
            logit_p_reg         <= 16'sd0;
            inv_temperature_reg <= 16'd2560;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:            mode_reg            <= cfg_data[0];
                CFG_DROP_THRESHOLD:  drop_threshold_reg  <= cfg_data;
                CFG_KEEP_SCALE:      keep_scale_reg      <= cfg_data;
                CFG_LOGIT_P:         logit_p_reg         <= cfg_data;
                CFG_INV_TEMPERATURE: inv_temperature_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // The whole pipeline moves when the output register can take a word.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Valid bits of the stages.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    // Table lookups: the logit read is addressed by the incoming word, the
    // sigmoid read by the clamped argument bin.
    logit_t                  logit_rd;
    sig_t                    sig_rd;
    logic [TABLE_BITS-1:0]   sig_idx_next;

    dma_tables #(
        .TABLE_BITS (TABLE_BITS)
    ) u_tables (
        .clk        (clk),
        .en         (advance),
        .logit_addr (random_word[15 -: TABLE_BITS]),
        .sig_addr   (sig_idx_next),
        .logit_data (logit_rd),
        .sig_data   (sig_rd)
    );

    // Stage 1: sign and magnitude of the activation.
    logic        s1_neg_reg, s1_last_reg;
    logic [15:0] s1_mag_reg, s1_word_reg;
    logic [15:0] s1_mag_next;

    assign s1_mag_next = activation[15] ? 16'(-activation) : 16'(activation);

    // Stage 2: sigmoid argument (logit_p + logit) * inv_temperature.
    logic        s2_neg_reg, s2_last_reg;
    logic [15:0] s2_mag_reg, s2_word_reg;
    logic signed [33:0] s2_arg_reg;
    logic signed [16:0] s2_sum;
    logic signed [33:0] s2_arg_next;

    assign s2_sum      = 17'(logit_p_reg) + 17'(logit_rd);
    assign s2_arg_next = 34'(s2_sum) * 34'($signed({1'b0, inv_temperature_reg}));

    // Stage 3: argument bin, clamped to the table range.
    logic        s3_neg_reg, s3_last_reg;
    logic [15:0] s3_mag_reg, s3_word_reg;
    logic signed [34:0] s3_pos;
    logic [SHW-1:0]     s3_bin;

    assign s3_pos = 35'(s2_arg_reg) + 35'sd4194304;
    assign s3_bin = s3_pos[33 -: SHW];

    always_comb
    begin
        if (s3_pos[34])
            sig_idx_next = '0;
        else if (|s3_bin[SHW-1:TABLE_BITS])
            sig_idx_next = TABLE_BITS'(TSIZE - 1);
        else
            sig_idx_next = s3_bin[TABLE_BITS-1:0];
    end

    // Stage 4: mask selection for the mode.
    logic        s4_neg_reg, s4_last_reg;
    logic [15:0] s4_mag_reg;
    logic [32:0] s4_mask_reg;
    logic [32:0] s4_mask_next;

    always_comb
    begin
        if (mode_reg == MODE_CONCRETE)
            s4_mask_next = 33'(sig_rd) * 33'(keep_scale_reg);
        else if (s3_word_reg < drop_threshold_reg)
            s4_mask_next = '0;
        else
            s4_mask_next = 33'(keep_scale_reg);
    end

    // Stage 5: magnitude times mask.
    logic        s5_neg_reg, s5_last_reg;
    logic [48:0] s5_prod_reg;

    // Stage 6: rounding and saturation into the output register.
    logic signed [15:0] out_value_reg, out_value_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_last_reg;
    logic [37:0]        s6_res;

    always_comb
    begin
        if (mode_reg == MODE_CONCRETE)
            s6_res = 38'((50'(s5_prod_reg) + (50'd1 << 27)) >> 28);
        else
            s6_res = 38'((50'(s5_prod_reg) + (50'd1 << 11)) >> 12);
        out_sat_next = 1'b0;
        if (s5_neg_reg)
        begin
            if (s6_res > 38'd32768)
            begin
                out_value_next = -16'sd32768;
                out_sat_next   = 1'b1;
            end
            else
                out_value_next = 16'(-s6_res);
        end
        else
        begin
            if (s6_res > 38'd32767)
            begin
                out_value_next = 16'sd32767;
                out_sat_next   = 1'b1;
            end
            else
                out_value_next = s6_res[15:0];
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_neg_reg    <= activation[15];
            s1_mag_reg    <= s1_mag_next;
            s1_word_reg   <= random_word;
            s1_last_reg   <= last_in;

            s2_neg_reg    <= s1_neg_reg;
            s2_mag_reg    <= s1_mag_reg;
            s2_word_reg   <= s1_word_reg;
            s2_last_reg   <= s1_last_reg;
            s2_arg_reg    <= s2_arg_next;

            s3_neg_reg    <= s2_neg_reg;
            s3_mag_reg    <= s2_mag_reg;
            s3_word_reg   <= s2_word_reg;
            s3_last_reg   <= s2_last_reg;

            s4_neg_reg    <= s3_neg_reg;
            s4_mag_reg    <= s3_mag_reg;
            s4_last_reg   <= s3_last_reg;
            s4_mask_reg   <= s4_mask_next;

            s5_neg_reg    <= s4_neg_reg;
            s5_last_reg   <= s4_last_reg;
            s5_prod_reg   <= 49'(s4_mag_reg) * 49'(s4_mask_reg);

            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_last_reg  <= s5_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scaled_value = out_value_reg;
    assign saturated    = out_sat_reg;
    assign last_out     = out_last_reg;

    // A clipped word sits exactly at one of the range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> scaled_value == 16'sh7FFF || scaled_value == -16'sh8000)
        else $error("saturated word is not at a range limit");

    // A zero mask always yields a zero product.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s4_valid_reg && s4_mask_reg == '0 |=> s5_prod_reg == '0)
        else $error("zero mask gave a nonzero product");

    // A zero product always yields an unclipped zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s5_valid_reg && s5_prod_reg == '0 |=> scaled_value == 16'sd0 && !saturated)
        else $error("zero product gave a nonzero word");

    // A held pipeline keeps its products.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s5_prod_reg) && $stable(s4_mask_reg))
        else $error("stage data changed during a stall");

    // The output valid bit follows the last stage when the pipeline moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid == $past(s5_valid_reg))
        else $error("output valid lost or invented");

endmodule

`default_nettype wire

[tb/sv/dropout_checker.sv]
// Checker for the dropout mask datapath: predicts every output word and compares it.
module dropout_checker
    import dma_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic signed [15:0]     activation,
    input  wire logic        [15:0]     random_word,
    input  wire logic                   last_in,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic signed [15:0]     scaled_value,
    input  wire logic                   saturated,
    input  wire logic                   last_out,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [15:0]     cfg_data,
    output int                          failures,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned LN2_FIX = 64'd744261118;

    typedef struct packed {
        logic signed [15:0] value;
        logic               sat;
        logic               last;
    } masked_word_t;

    // Local copies of the two lookup tables.
    logit_t logit_lut [TSIZE];
    sig_t   sigmoid_lut [TSIZE];

    // Shadow of the configuration registers, loaded with the reset defaults.
    logic               mode_r     = MODE_MC;
    logic        [15:0] thr_r      = 16'd32768;
    logic        [15:0] keep_r     = 16'd8192;
    logic signed [15:0] logit_p_r  = 16'sd0;
    logic        [15:0] inv_temp_r = 16'd2560;

    masked_word_t awaited_words [$];
    int fail_count = 0;

    assign failures = fail_count;
    assign pending  = awaited_words.size();

    // Base-2 logarithm of a small integer in Q30, one fraction bit per squaring.
    function automatic longint unsigned log2_q30(longint unsigned x);
        longint unsigned m;
        longint unsigned frac;
        int k;
        int b;
        k = 0;
        while ((x >> (k + 1)) != 0 && k < 20)
            k++;
        m = x << (30 - k);
        frac = 0;
        for (b = 29; b >= 0; b--)
        begin
            m = (m * m) >> 30;
            if (m >= (ONE_Q30 << 1))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << b);
            end
        end
        return (64'(k) << 30) | frac;
    endfunction

    // e to the minus y in Q30: split off whole multiples of ln2, series on the rest.
    function automatic longint unsigned exp_neg_q30(longint unsigned y);
        longint unsigned n;
        longint unsigned r;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned k;
        n = y / LN2_FIX;
        r = y - n * LN2_FIX;
        sum = ONE_Q30;
        term = ONE_Q30;
        for (k = 1; k <= 20; k++)
        begin
            term = ((term * r) >> 30) / k;
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (n >= 63) ? 64'd0 : (sum >> n);
    endfunction

    // Fill both tables once at the start of the run.
    initial
    begin
        longint unsigned full;
        longint unsigned half;
        longint unsigned a;
        longint unsigned la;
        longint unsigned lb;
        longint unsigned d;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        int i;
        full = 64'd1 << (TABLE_BITS + 1);
        half = 64'd1 << 34;
        for (i = 0; i < TSIZE; i++)
        begin
            a = 2 * i + 1;
            la = log2_q30(a);
            lb = log2_q30(full - a);
            d = (la < lb) ? lb - la : la - lb;
            mag = (((d >> 8) * LN2_FIX) + (64'd1 << 41)) >> 42;
            logit_lut[i] = (la < lb) ? -logit_t'(mag) : logit_t'(mag);
        end
        for (i = 0; i < TSIZE; i++)
        begin
            a = 2 * i + 1;
            a = a << (34 - TABLE_BITS);
            if (a >= half)
            begin
                e = exp_neg_q30(a - half);
                den = ONE_Q30 + e;
                sigmoid_lut[i] = sig_t'(((e << 16) + den / 2) / den);
            end
            else
            begin
                e = exp_neg_q30(half - a);
                den = ONE_Q30 + e;
                sigmoid_lut[i] = sig_t'(((ONE_Q30 << 16) + den / 2) / den);
            end
        end
    end

    // Expected output word for one input word under the current settings.
    function automatic masked_word_t apply_mask(logic signed [15:0] act, logic [15:0] word,
                                                logic last);
        masked_word_t r;
        longint a64;
        longint mag;
        longint mask;
        longint res;
        longint lsum;
        longint temp;
        longint arg;
        longint pos;
        longint scale;
        int shift;
        int idx;
        logic [15:0] w;
        a64 = act;
        mag = (a64 < 0) ? -a64 : a64;
        scale = keep_r;
        if (mode_r == MODE_MC)
        begin
            mask = (word < thr_r) ? 0 : scale;
            shift = 12;
        end
        else
        begin
            // A random word of zero has no finite logit, so it is read as one.
            w = (word == 16'd0) ? 16'd1 : word;
            lsum = logit_p_r;
            lsum = lsum + logit_lut[w >> (16 - TABLE_BITS)];
            temp = inv_temp_r;
            arg = lsum * temp;
            pos = arg + (64'sd1 <<< 22);
            // Arguments outside [-16, 16) read the first or the last entry.
            if (pos < 0)
                idx = 0;
            else if ((pos >>> (23 - TABLE_BITS)) > TSIZE - 1)
                idx = TSIZE - 1;
            else
                idx = int'(pos >>> (23 - TABLE_BITS));
            mask = sigmoid_lut[idx];
            mask = mask * scale;
            shift = 28;
        end
        res = (mag * mask + (64'sd1 <<< (shift - 1))) >>> shift;
        if (mask == 0)
            res = 0;
        r.sat = 1'b0;
        r.last = last;
        if (a64 < 0)
        begin
            if (res > 32768)
            begin
                res = 32768;
                r.sat = 1'b1;
            end
            r.value = 16'(-res);
        end
        else
        begin
            if (res > 32767)
            begin
                res = 32767;
                r.sat = 1'b1;
            end
            r.value = 16'(res);
        end
        return r;
    endfunction

    // Track register writes, queue a prediction per input word, check each output word.
    always @(posedge clk)
    begin
        masked_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:            mode_r <= cfg_data[0];
                    CFG_DROP_THRESHOLD:  thr_r <= cfg_data;
                    CFG_KEEP_SCALE:      keep_r <= cfg_data;
                    CFG_LOGIT_P:         logit_p_r <= cfg_data;
                    CFG_INV_TEMPERATURE: inv_temp_r <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                awaited_words.push_back(apply_mask(activation, random_word, last_in));
            if (out_valid && !out_stall)
            begin
                if (awaited_words.size() == 0)
                begin
                    $error("output word arrived with nothing awaited: value %0d", scaled_value);
                    fail_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (scaled_value !== want.value)
                    begin
                        $error("scaled_value: expected %0d, got %0d", want.value, scaled_value);
                        fail_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0b, got %0b", want.sat, saturated);
                        fail_count++;
                    end
                    if (last_out !== want.last)
                    begin
                        $error("last_out: expected %0b, got %0b", want.last, last_out);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the dropout mask testbench: clock, reset, stimulus, output stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dma_pkg::*;

    localparam int TABLE_BITS     = 10;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int MAX_GAP        = 8;
    localparam int HOLD_CYCLES    = 64;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 80;
    localparam int PRESSURE_PHASE = 3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [15:0]     activation = 16'sd0;
    logic        [15:0]     random_word = 16'd0;
    logic                   last_in = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [15:0]     scaled_value;
    logic                   saturated;
    logic                   last_out;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic        [15:0]     cfg_data = 16'd0;
    int                     failures;
    int                     pending;

    // Idle controls of the sender and the receiver, the current threshold and the idle count.
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    logic        hold_req = 1'b0;
    logic [15:0] thr_now = 16'd32768;
    int          idle_cycles = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    dropout_mask_apply #(.TABLE_BITS(TABLE_BITS)) i_dut (.*);

    dropout_checker #(.TABLE_BITS(TABLE_BITS)) i_checker (.*);

    // Offer one input word after a random gap and hold it until it is taken.
    task automatic offer_element(logic signed [15:0] act, logic [15:0] word, logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        activation <= act;
        random_word <= word;
        last_in <= last;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering words and wait until every predicted word has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (index == CFG_DROP_THRESHOLD)
            thr_now = data;
    endtask

    // Register value: either extreme, a typical value, or anything at all.
    function automatic logic [15:0] draw_reg(logic [15:0] lo, logic [15:0] hi,
                                             logic [15:0] mid);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            2: return mid;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: a random stall before each word, plus one long hold on request.
    initial
    begin
        int stall_len;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall_len = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                stall_len = stall_len + HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: too long without any word moving on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed corner cases first, then randomized phases.
    initial
    begin
        logic signed [15:0] act;
        logic        [15:0] word;
        int j;
        int ph;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Writes past the end of the register list must change nothing.
        for (j = CFG_INV_TEMPERATURE + 1; j < (1 << CFG_INDEX_W); j++)
            write_reg(CFG_INDEX_W'(j), 16'hFFFF);

        // Monte Carlo at the reset settings: saturation both ways, drop edge, zero.
        offer_element(16'sh7FFF, 16'hFFFF, 1'b0);
        offer_element(16'sh8000, 16'hFFFF, 1'b0);
        offer_element(16'sh8000, 16'h0000, 1'b1);
        offer_element(16'sh0000, 16'h8000, 1'b0);
        offer_element(16'sh0100, 16'h7FFF, 1'b0);
        offer_element(16'sh0100, 16'h8000, 1'b1);
        offer_element(16'shFFFF, 16'hC000, 1'b0);
        drain_results();

        // Concrete mode at default settings, including the zero random word.
        write_reg(CFG_MODE, {15'd0, MODE_CONCRETE});
        offer_element(16'sh0100, 16'h0000, 1'b0);
        offer_element(16'sh0100, 16'h0001, 1'b0);
        offer_element(16'sh7FFF, 16'hFFFF, 1'b1);
        offer_element(16'sh8000, 16'h8000, 1'b0);
        offer_element(16'shFF00, 16'h0040, 1'b0);
        drain_results();

        // Argument far below the table range, then far above it.
        write_reg(CFG_LOGIT_P, 16'h8000);
        write_reg(CFG_INV_TEMPERATURE, 16'hFFFF);
        write_reg(CFG_KEEP_SCALE, 16'hFFFF);
        offer_element(16'sh7FFF, 16'h0000, 1'b0);
        offer_element(16'sh8000, 16'hFFFF, 1'b1);
        drain_results();
        write_reg(CFG_LOGIT_P, 16'h7FFF);
        offer_element(16'sh7FFF, 16'h0000, 1'b0);
        offer_element(16'sh8000, 16'hFFFF, 1'b0);
        drain_results();

        // Zero temperature factor lands mid table; zero keep scale drops everything.
        write_reg(CFG_INV_TEMPERATURE, 16'h0000);
        offer_element(16'sh1234, 16'h5555, 1'b0);
        drain_results();
        write_reg(CFG_KEEP_SCALE, 16'h0000);
        offer_element(16'sh7FFF, 16'hAAAA, 1'b1);
        drain_results();

        // Monte Carlo with the threshold at both extremes.
        write_reg(CFG_MODE, {15'd0, MODE_MC});
        write_reg(CFG_KEEP_SCALE, 16'hFFFF);
        write_reg(CFG_DROP_THRESHOLD, 16'h0000);
        offer_element(16'sh0001, 16'h0000, 1'b0);
        offer_element(16'sh8000, 16'h0000, 1'b0);
        drain_results();
        write_reg(CFG_DROP_THRESHOLD, 16'hFFFF);
        offer_element(16'sh7FFF, 16'hFFFE, 1'b0);
        offer_element(16'sh0010, 16'hFFFF, 1'b1);

        // Random phases, each with fresh settings and its own idle behavior.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            write_reg(CFG_MODE, {15'($urandom), 1'($urandom)});
            write_reg(CFG_DROP_THRESHOLD,
                      draw_reg(16'h0000, 16'hFFFF, 16'($urandom_range(16384, 49152))));
            write_reg(CFG_KEEP_SCALE,
                      draw_reg(16'h0000, 16'hFFFF, 16'($urandom_range(4096, 16384))));
            write_reg(CFG_LOGIT_P,
                      draw_reg(16'h8000, 16'h7FFF, 16'($urandom_range(0, 6000) - 3000)));
            write_reg(CFG_INV_TEMPERATURE,
                      draw_reg(16'h0000, 16'hFFFF, 16'($urandom_range(64, 4096))));
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            // Back-to-back input against a long output hold fills the pipeline.
            if (ph == PRESSURE_PHASE)
            begin
                tx_calm = 1'b1;
                hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                case ($urandom_range(0, 7))
                    0: act = 16'sh7FFF;
                    1: act = 16'sh8000;
                    2, 3: act = 16'($urandom_range(0, 1023) - 512);
                    default: act = 16'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0: word = 16'h0000;
                    1: word = 16'hFFFF;
                    2: word = thr_now + 16'($urandom_range(0, 2)) - 16'd1;
                    default: word = 16'($urandom);
                endcase
                offer_element(act, word, $urandom_range(0, 7) == 0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
